@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the property holds on every clock edge out of reset.
`define OMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks the property during reset as well.
`define OMC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/omc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omc_pkg
// Shared types and constants of the online fragment chainer.
// ----------------------------------------------------------------------------
package omc_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SCORE_W      = 40;

    localparam logic [0:0] CFG_SAME_DIAG = 1'b0;
    localparam logic [0:0] CFG_MAX_DIST  = 1'b1;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef struct packed {
        logic [31:0]        len;
        logic [31:0]        first;
        logic [31:0]        second;
        logic [SCORE_W-1:0] score;
        logic [31:0]        id;
        logic [31:0]        head_id;
        logic [31:0]        clen;
    } t_entry;

    // Memory write request from the controller.
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        t_entry           wdata;
    } t_mem_wr;

endpackage

@@ hdl/omc_window_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omc_window_ram
// Window store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module omc_window_ram (
    input  logic                        i_clk,
    input  omc_pkg::t_mem_wr            i_wr,
    input  logic [omc_pkg::PTR_W-1:0]   i_raddr,
    output omc_pkg::t_entry             o_rdata
);

    omc_pkg::t_entry r_mem [omc_pkg::WINDOW_DEPTH];
    omc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.waddr] <= i_wr.wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/omc_score_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omc_score_unit
// Gap, compatibility and candidate score of one window entry.
// ----------------------------------------------------------------------------
module omc_score_unit (
    input  omc_pkg::t_entry              i_l,
    input  logic [31:0]                  i_len,
    input  logic [31:0]                  i_first,
    input  logic [31:0]                  i_second,
    input  logic                         i_same_diag,
    input  logic [31:0]                  i_max_dist,
    output logic                         o_ok,
    output logic [omc_pkg::SCORE_W-1:0]  o_score
);

    logic signed [34:0] a, b, gap;
    logic [32:0] lend_f, lend_s;
    logic signed [42:0] s;
    logic [42:0] sc;
    logic nonov, diag;

    always_comb begin
        lend_f = {1'b0, i_l.first} + {1'b0, i_l.len};
        lend_s = {1'b0, i_l.second} + {1'b0, i_l.len};
        a = $signed({3'b0, i_first}) - $signed({2'b0, lend_f});
        b = $signed({3'b0, i_second}) - $signed({2'b0, lend_s});
        if (a < 0) a = '0;
        if (b < 0) b = '0;
        gap = (a > b) ? a : b;
        nonov = (lend_f <= {1'b0, i_first}) && (lend_s <= {1'b0, i_second});
        // Equal diagonals: l.second - l.first == r.second - r.first.
        diag = i_same_diag
            && ({1'b0, i_l.second} + {1'b0, i_first} == {1'b0, i_second} + {1'b0, i_l.first})
            && (i_l.first < i_first);
        s = $signed({3'b0, i_l.score}) - $signed({8'b0, gap});
        o_ok = (gap <= $signed({3'b0, i_max_dist})) && (nonov || diag) && (s > 0);
        sc = 43'(s) + {11'b0, i_len};
        o_score = (sc > {3'b0, omc_pkg::SCORE_MAX}) ? omc_pkg::SCORE_MAX
                                                    : sc[omc_pkg::SCORE_W-1:0];
    end

endmodule

@@ hdl/online_match_chainer_top.sv @@
`timescale 1ns / 1ps
// After a fragment is accepted, entries too far behind it are evicted from the window head,
// the window is scanned for the best predecessor, that entry is read back when one is found,
// and the result is shown. One fragment at a time: a new one is taken only once the result
// of the last one has been taken by the receiver.
// Reset (synchronous, active low) empties the window, zeroes the id counter
// and both configuration registers; the window memory itself is not cleared.
`include "assert_macros.svh"
module online_match_chainer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_frag_length,
    input  logic [31:0] i_start_first,
    input  logic [31:0] i_start_second,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_frag_id,
    output logic [39:0] o_chain_score,
    output logic        o_has_predecessor,
    output logic [31:0] o_predecessor_id,
    output logic [31:0] o_chain_head_id,
    output logic [31:0] o_chain_length,
    output logic        o_window_overflow,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int PW = omc_pkg::PTR_W;
    localparam int CW = omc_pkg::CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVRD  = 3'd1;
    localparam logic [2:0] S_EVCHK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_PRED  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic          r_same_diag;
    logic [31:0]   r_max_dist;
    logic [PW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_next_id;
    logic [31:0]   r_len, r_first, r_second;
    logic [CW-1:0] r_k;        // entries issued to the memory
    logic          r_rvld;     // read data valid this cycle
    logic          r_found;
    logic [omc_pkg::SCORE_W-1:0] r_best;
    logic [PW-1:0] r_best_slot;
    logic          r_ovf;
    logic          r_ovalid;
    omc_pkg::t_entry r_res;
    logic [31:0]   r_pred_id;

    logic [PW-1:0]     raddr;
    omc_pkg::t_entry   rdata;
    omc_pkg::t_mem_wr  wr;
    logic              cand_ok;
    logic [omc_pkg::SCORE_W-1:0] cand_score;
    logic [33:0]       evict_lhs;
    logic              accept;

    // The result registers are reused by the next fragment, so a pending beat blocks input.
    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign accept  = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    omc_window_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    omc_score_unit u_score (
        .i_l         (rdata),
        .i_len       (r_len),
        .i_first     (r_first),
        .i_second    (r_second),
        .i_same_diag (r_same_diag),
        .i_max_dist  (r_max_dist),
        .o_ok        (cand_ok),
        .o_score     (cand_score)
    );

    assign evict_lhs = {2'b0, rdata.second} + {2'b0, rdata.len} + {2'b0, r_max_dist} + 34'd1;

    always_comb begin
        raddr = r_head;
        case (r_state)
            S_SCAN:  raddr = r_head + r_k[PW-1:0];
            S_FIN:   raddr = r_best_slot;
            S_PRED:  raddr = r_best_slot;
            default: raddr = r_head;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        wr.we    = 1'b0;
        wr.waddr = r_head + r_count[PW-1:0];
        wr.wdata = r_res;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_EVRD;
            S_EVRD:  n_state = (r_count == '0) ? S_SCAN : S_EVCHK;
            S_EVCHK: begin
                if (evict_lhs < {2'b0, r_second}) begin
                    n_head  = r_head + 1'b1;
                    n_count = r_count - 1'b1;
                    n_state = S_EVRD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN:  if (r_k == r_count && !r_rvld) n_state = S_FIN;
            S_FIN:   n_state = r_found ? S_PRED : S_OUT;
            S_PRED:  if (r_rvld) n_state = S_OUT;
            S_OUT: begin
                // Full window drops its oldest entry before the insert.
                if (r_count == CW'(omc_pkg::WINDOW_DEPTH)) begin
                    n_head  = r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end
                wr.we    = 1'b1;
                wr.waddr = n_head + n_count[PW-1:0];
                n_count  = n_count + 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_same_diag <= 1'b0;
            r_max_dist  <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_next_id   <= '0;
            r_ovalid    <= 1'b0;
            r_rvld      <= 1'b0;
            r_k         <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    omc_pkg::CFG_SAME_DIAG: r_same_diag <= i_cfg_data[0];
                    omc_pkg::CFG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            r_rvld <= 1'b0;
            case (r_state)
                S_IDLE: if (accept) begin
                    r_k     <= '0;
                    r_found <= 1'b0;
                end
                S_SCAN: begin
                    if (r_k != r_count) begin
                        r_k    <= r_k + 1'b1;
                        r_rvld <= 1'b1;
                    end
                    if (r_rvld && cand_ok && (!r_found || cand_score > r_best)) begin
                        r_found     <= 1'b1;
                        r_best      <= cand_score;
                        r_best_slot <= r_head + PW'(r_k - 1'b1);
                    end
                end
                S_FIN: r_rvld <= r_found;
                S_OUT: begin
                    r_ovalid  <= 1'b1;
                    r_next_id <= r_next_id + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_len    <= i_frag_length;
            r_first  <= i_start_first;
            r_second <= i_start_second;
        end
        case (r_state)
            S_FIN: begin
                r_res.len     <= r_len;
                r_res.first   <= r_first;
                r_res.second  <= r_second;
                r_res.score   <= {8'b0, r_len};
                r_res.id      <= r_next_id;
                r_res.head_id <= r_next_id;
                r_res.clen    <= 32'd1;
                r_pred_id     <= '0;
                r_ovf         <= 1'b0;
            end
            S_PRED: if (r_rvld) begin
                r_res.score   <= r_best;
                r_res.head_id <= rdata.head_id;
                r_res.clen    <= (rdata.clen != 32'hFFFF_FFFF) ? rdata.clen + 1'b1 : rdata.clen;
                r_pred_id     <= rdata.id;
            end
            S_OUT: r_ovf <= (r_count == CW'(omc_pkg::WINDOW_DEPTH));
            default: ;
        endcase
    end

    assign o_valid           = r_ovalid;
    assign o_frag_id         = r_res.id;
    assign o_chain_score     = r_res.score;
    assign o_has_predecessor = (r_res.clen != 32'd1) || (r_pred_id != '0) ||
                               (r_res.head_id != r_res.id);
    assign o_predecessor_id  = r_pred_id;
    assign o_chain_head_id   = r_res.head_id;
    assign o_chain_length    = r_res.clen;
    assign o_window_overflow = r_ovf;

    `OMC_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(omc_pkg::WINDOW_DEPTH), "count over depth")
    `OMC_ASSERT(a_out_after_out, i_clk, i_rst_n, (r_state == S_OUT) |=> r_ovalid, "result not shown")
    `OMC_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_k <= r_count), "scan overrun")

endmodule

@@ test/tb_online_match_chainer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_online_match_chainer_top
// Feeds match fragments to the chainer under a changing gap limit and
// diagonal mode, and compares each reported beat with a local prediction.
// ----------------------------------------------------------------------------
module tb_online_match_chainer_top;

    typedef struct {
        logic [31:0] len;
        logic [31:0] first;
        logic [31:0] second;
    } t_frag;

    typedef struct {
        logic [31:0]                 frag_id;
        logic [omc_pkg::SCORE_W-1:0] score;
        logic                        has_pred;
        logic [31:0]                 pred_id;
        logic [31:0]                 head_id;
        logic [31:0]                 clen;
        logic                        overflow;
    } t_chain_rpt;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_frag_length = '0;
    logic [31:0] i_start_first = '0;
    logic [31:0] i_start_second = '0;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_frag_id;
    logic [39:0] o_chain_score;
    logic        o_has_predecessor;
    logic [31:0] o_predecessor_id;
    logic [31:0] o_chain_head_id;
    logic [31:0] o_chain_length;
    logic        o_window_overflow;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    online_match_chainer_top dut (.*);

    // Predictor state.
    omc_pkg::t_entry win [omc_pkg::WINDOW_DEPTH];
    int          win_head = 0;
    int          win_count = 0;
    logic [31:0] id_next = '0;
    logic        same_diag;
    logic [31:0] gap_limit;

    t_frag       frag_q [$];
    t_chain_rpt  chain_q [$];
    int          errors = 0;
    int          hold_off;
    bit          long_hold;
    bit          long_hold_seen;
    bit          feeding_done;
    logic [31:0] pos2;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint frag_gap(omc_pkg::t_entry l, t_frag r);
        longint a;
        longint b;
        a = longint'(r.first) - (longint'(l.first) + longint'(l.len));
        b = longint'(r.second) - (longint'(l.second) + longint'(l.len));
        if (a < 0) a = 0;
        if (b < 0) b = 0;
        return (a > b) ? a : b;
    endfunction

    function automatic t_chain_rpt chain_predict(t_frag f);
        t_chain_rpt      r;
        omc_pkg::t_entry cur;
        omc_pkg::t_entry l;
        bit         found;
        longint     best;
        longint     s;
        longint     g;
        int         best_slot;
        int         slot;
        bit         ok;
        found = 0;
        best = 0;
        best_slot = 0;
        cur.len = f.len;
        cur.first = f.first;
        cur.second = f.second;
        cur.score = {8'b0, f.len};
        cur.id = id_next;
        cur.head_id = id_next;
        cur.clen = 1;
        while (win_count > 0) begin
            l = win[win_head];
            if (longint'(l.second) + longint'(l.len) + longint'(gap_limit) + 1
                    >= longint'(f.second)) break;
            win_head = (win_head + 1) % omc_pkg::WINDOW_DEPTH;
            win_count--;
        end
        for (int k = 0; k < win_count; k++) begin
            slot = (win_head + k) % omc_pkg::WINDOW_DEPTH;
            l = win[slot];
            g = frag_gap(l, f);
            ok = 0;
            if (g <= longint'(gap_limit)) begin
                if (longint'(l.first) + l.len <= longint'(f.first) &&
                    longint'(l.second) + l.len <= longint'(f.second)) ok = 1;
                else if (same_diag &&
                         longint'(l.second) - l.first == longint'(f.second) - f.first &&
                         l.first < f.first) ok = 1;
            end
            if (!ok) continue;
            s = longint'(l.score) - g;
            if (s <= 0) continue;
            s = s + f.len;
            if (s > longint'(omc_pkg::SCORE_MAX)) s = longint'(omc_pkg::SCORE_MAX);
            if (!found || s > best) begin
                found = 1;
                best = s;
                best_slot = slot;
            end
        end
        r.has_pred = found;
        r.pred_id = 0;
        if (found) begin
            l = win[best_slot];
            cur.score = best[omc_pkg::SCORE_W-1:0];
            cur.head_id = l.head_id;
            cur.clen = (l.clen != 32'hFFFF_FFFF) ? l.clen + 1 : l.clen;
            r.pred_id = l.id;
        end
        r.overflow = 0;
        if (win_count >= omc_pkg::WINDOW_DEPTH) begin
            win_head = (win_head + 1) % omc_pkg::WINDOW_DEPTH;
            win_count = omc_pkg::WINDOW_DEPTH - 1;
            r.overflow = 1;
        end
        win[(win_head + win_count) % omc_pkg::WINDOW_DEPTH] = cur;
        win_count++;
        id_next++;
        r.frag_id = cur.id;
        r.score = cur.score;
        r.head_id = cur.head_id;
        r.clen = cur.clen;
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Driver: predictions are made as each beat is accepted.
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                chain_q.push_back(chain_predict('{i_frag_length, i_start_first,
                                                  i_start_second}));
                void'(frag_q.pop_front());
            end
            if (i_valid && o_stall) begin
                // Hold the stalled beat.
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (frag_q.size() > 0) begin
                t_frag f;
                f = frag_q[0];
                i_valid <= 1'b1;
                i_frag_length <= f.len;
                i_start_first <= f.first;
                i_start_second <= f.second;
                send_gap <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver with random stalls and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_off <= 0;
            long_hold_seen <= 1'b0;
        end else if (long_hold && !long_hold_seen) begin
            long_hold_seen <= 1'b1;
            hold_off <= 600;
            i_stall <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 9) < 9 ? 1'b1 : 1'b1)
                                                    : 1'b0;
            if ($urandom_range(0, 60) == 0) hold_off <= $urandom_range(3, 30);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_chain_rpt e;
            if (chain_q.size() == 0) begin
                $display("%0t: unexpected result frag_id=%0d", $time, o_frag_id);
                errors++;
            end else begin
                e = chain_q.pop_front();
                if (o_frag_id !== e.frag_id || o_chain_score !== e.score ||
                    o_has_predecessor !== e.has_pred || o_predecessor_id !== e.pred_id ||
                    o_chain_head_id !== e.head_id || o_chain_length !== e.clen ||
                    o_window_overflow !== e.overflow) begin
                    $display("%0t: mismatch expected id=%0d sc=%0d hp=%0b pid=%0d hd=%0d len=%0d ov=%0b",
                             $time, e.frag_id, e.score, e.has_pred, e.pred_id,
                             e.head_id, e.clen, e.overflow);
                    $display("%0t:          actual id=%0d sc=%0d hp=%0b pid=%0d hd=%0d len=%0d ov=%0b",
                             $time, o_frag_id, o_chain_score, o_has_predecessor,
                             o_predecessor_id, o_chain_head_id, o_chain_length,
                             o_window_overflow);
                    errors++;
                end
            end
        end
    end

    task automatic cfg_write(input logic idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == omc_pkg::CFG_SAME_DIAG) same_diag = data[0];
        else gap_limit = data;
    endtask

    task automatic drain();
        while (frag_q.size() != 0 || chain_q.size() != 0 || i_valid) @(posedge i_clk);
        repeat (2 * omc_pkg::WINDOW_DEPTH + 20) @(posedge i_clk);
    endtask

    task automatic add_frag(input logic [31:0] l, input logic [31:0] a,
                            input logic [31:0] b);
        frag_q.push_back('{l, a, b});
    endtask

    // Mostly well-formed chains: fragments along a few diagonals with small gaps.
    task automatic add_random(input int n, input int gap_max);
        logic [31:0] l;
        logic [31:0] a;
        int          pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 19);
            l = $urandom_range(1, 20);
            pos2 += $urandom_range(0, gap_max);
            a = pos2 - $urandom_range(0, 3) * 7;
            if (pick == 0) l = $urandom;
            else if (pick == 1) a = $urandom;
            else if (pick == 2) l = 32'hFFFF_FFFF - $urandom_range(0, 3);
            else if (pick == 3) pos2 = $urandom;
            add_frag(l, a, pos2);
        end
    endtask

    initial begin
        same_diag = 0;
        gap_limit = 0;
        pos2 = 0;
        long_hold = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = omc_pkg::CFG_SAME_DIAG;
        i_cfg_data = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, then touching and overlapping fragments.
        add_frag(32'd10, 32'd0, 32'd0);
        add_frag(32'd5, 32'd10, 32'd10);
        add_frag(32'd5, 32'd12, 32'd12);
        add_frag(32'd0, 32'd20, 32'd15);
        add_frag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_frag(32'd1, 32'd0, 32'd5);
        drain();
        cfg_write(omc_pkg::CFG_SAME_DIAG, 32'd1);
        cfg_write(omc_pkg::CFG_MAX_DIST, 32'd100);
        pos2 = 1000;
        add_frag(32'd20, 32'd1000, 32'd1000);
        add_frag(32'd20, 32'd1005, 32'd1005);
        add_frag(32'd3, 32'd1030, 32'd1060);
        add_frag(32'd3, 32'd1200, 32'd1200);
        add_frag(32'd4, 32'd1199, 32'd1199);
        add_frag(32'd50, 32'd1300, 32'd1500);
        add_frag(32'hFFFF_FFFF, 32'd0, 32'd1500);
        add_frag(32'd1, 32'hFFFF_FFFF, 32'd1400);
        drain();
        cfg_write(omc_pkg::CFG_MAX_DIST, 32'hFFFF_FFFF);
        add_frag(32'hFFFF_FFFF, 32'd0, 32'd0);
        add_frag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_frag(32'd7, 32'd7, 32'hFFFF_FFFF);
        // Fill past the window depth to force overflow.
        for (int i = 0; i < omc_pkg::WINDOW_DEPTH + 4; i++)
            add_frag(32'd1, 32'(i), 32'hFFFF_FFFF);
        drain();

        // Random phases over several settings; a long hold-off in the first.
        cfg_write(omc_pkg::CFG_SAME_DIAG, 32'd0);
        cfg_write(omc_pkg::CFG_MAX_DIST, 32'd30);
        pos2 = $urandom;
        add_random(350, 12);
        long_hold = 1'b1;
        drain();
        cfg_write(omc_pkg::CFG_SAME_DIAG, 32'd1);
        cfg_write(omc_pkg::CFG_MAX_DIST, 32'd0);
        add_random(300, 3);
        drain();
        cfg_write(omc_pkg::CFG_MAX_DIST, 32'hFFFF_FFFF);
        add_random(300, 8);
        drain();
        cfg_write(omc_pkg::CFG_SAME_DIAG, 32'd0);
        cfg_write(omc_pkg::CFG_MAX_DIST, $urandom_range(1, 200));
        add_random(350, 20);
        drain();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
